### hdl/cpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-8 packet framer package
// Shared types, link constants and the CRC-8 byte update used by the framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam logic [7:0] START_BYTE = 8'h5B;
  localparam logic [7:0] CRC_POLY   = 8'h85;

  typedef enum logic {
    MODE_HEADER  = 1'b0,
    MODE_PAYLOAD = 1'b1
  } mode_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic [7:0] response_code;
    mode_t      mode;
  } item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] msg, input logic [7:0] crc);
    logic [7:0] c;
    logic       carry;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      carry = c[7];
      c = {c[6:0], msg[k]};
      if (carry) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  localparam logic [7:0] CRC_START = crc8_byte(START_BYTE, 8'h00);

endpackage
`default_nettype wire

### hdl/crc8_packet_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-8 packet framer
// Builds length-prefixed response packets closed by a CRC-8 byte.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser selects a header (0) or a
// payload byte (1). A header sends the start byte, the response code and
// the length; a zero length sends the CRC byte at once. Payload bytes of an
// open packet pass through, and the last one is followed by the CRC byte.
// Payload bytes outside an open packet are dropped without output; a new
// header abandons an open packet.
// Output bytes leave on m_axis: tuser marks the CRC byte, tlast marks the
// last byte caused by a request.
// Each output byte is registered in the output register before m_axis. A
// request holds the input register until its last output byte enters the
// output register: a payload byte yields one byte, the closing payload byte
// two, a header three or four, so payload streams at one byte per cycle
// while m_axis_tready stays high; a dropped request leaves without output.
// When m_axis_tready is low with a byte waiting, the output register holds
// its byte and the input register its request, so s_axis_tready falls.
// Reset clears the packet state (no packet open, CRC zero) and both
// registers' valid flags.
// ----------------------------------------------------------------------------
module crc8_packet_framer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // payload_byte, payload_length, response_code
  input  wire logic        s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // tx_byte
  output logic             m_axis_tuser,  // end_of_packet
  output logic             m_axis_tlast   // end_of_run
);

  logic           in_valid;
  cpf_pkg::item_t item;
  logic           consume;

  assign s_axis_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.mode           <= cpf_pkg::mode_t'(s_axis_tuser);
      item.response_code  <= s_axis_tdata[7:0];
      item.payload_length <= s_axis_tdata[15:8];
      item.payload_byte   <= s_axis_tdata[23:16];
    end
  end

  cpf_framer u_framer (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (in_valid),
    .item          (item),
    .consume       (consume),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

### hdl/cpf_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-8 packet framer core
// Holds the packet state and steps one buffered request through its output
// bytes into the output register, one per cycle unless m_axis stalls.
// ----------------------------------------------------------------------------
module cpf_framer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire cpf_pkg::item_t item,
  output logic               consume,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // tx_byte
  output logic               m_axis_tuser,  // end_of_packet
  output logic               m_axis_tlast
);

  logic [1:0] step;
  logic [1:0] step_next;
  logic [7:0] running_crc;
  logic [7:0] running_crc_next;
  logic [7:0] bytes_remaining;
  logic [7:0] bytes_remaining_next;
  logic       packet_open;
  logic       packet_open_next;

  logic       emit;
  logic       drop;
  logic       advance;
  logic [7:0] res_byte;
  logic       res_eop;
  logic       res_last;

  always_comb begin
    emit                 = 1'b0;
    drop                 = 1'b0;
    res_byte             = 8'h00;
    res_eop              = 1'b0;
    res_last             = 1'b0;
    running_crc_next     = running_crc;
    bytes_remaining_next = bytes_remaining;
    packet_open_next     = packet_open;
    if (item_valid) begin
      if (item.mode == cpf_pkg::MODE_HEADER) begin
        emit = 1'b1;
        case (step)
          2'd0: begin
            res_byte         = cpf_pkg::START_BYTE;
            running_crc_next = cpf_pkg::CRC_START;
          end
          2'd1: begin
            res_byte         = item.response_code;
            running_crc_next = cpf_pkg::crc8_byte(item.response_code, running_crc);
          end
          2'd2: begin
            res_byte         = item.payload_length;
            running_crc_next = cpf_pkg::crc8_byte(item.payload_length, running_crc);
            if (item.payload_length != 8'h00) begin
              res_last             = 1'b1;
              packet_open_next     = 1'b1;
              bytes_remaining_next = item.payload_length;
            end
          end
          default: begin
            res_byte             = cpf_pkg::crc8_byte(8'h00, running_crc);
            res_eop              = 1'b1;
            res_last             = 1'b1;
            running_crc_next     = 8'h00;
            packet_open_next     = 1'b0;
            bytes_remaining_next = 8'h00;
          end
        endcase
      end else if (step == 2'd0 && (!packet_open || bytes_remaining == 8'h00)) begin
        drop = 1'b1;
      end else begin
        emit = 1'b1;
        if (step == 2'd0) begin
          res_byte             = item.payload_byte;
          running_crc_next     = cpf_pkg::crc8_byte(item.payload_byte, running_crc);
          bytes_remaining_next = bytes_remaining - 8'd1;
          res_last             = (bytes_remaining != 8'd1);
        end else begin
          res_byte         = cpf_pkg::crc8_byte(8'h00, running_crc);
          res_eop          = 1'b1;
          res_last         = 1'b1;
          running_crc_next = 8'h00;
          packet_open_next = 1'b0;
        end
      end
    end
    advance = emit && (!m_axis_tvalid || m_axis_tready);
    consume = drop || (advance && res_last);
    if (consume) begin
      step_next = 2'd0;
    end else if (advance) begin
      step_next = step + 2'd1;
    end else begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= 2'd0;
      running_crc     <= 8'h00;
      bytes_remaining <= 8'h00;
      packet_open     <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      step <= step_next;
      if (advance) begin
        running_crc     <= running_crc_next;
        bytes_remaining <= bytes_remaining_next;
        packet_open     <= packet_open_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= res_byte;
      m_axis_tuser <= res_eop;
      m_axis_tlast <= res_last;
    end
  end

endmodule
`default_nettype wire
